// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// each macro expects clk and arst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: invariant violated");
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");
`else
`define ASSERT_HOLDS(lbl, prop)
`define ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

// File: rtl/ghp_pkg.sv
// ghp_pkg: sizes, operation and status codes, and memory entry types
// of the generational handle pool; no dependencies
`default_nettype none
package ghp_pkg;
	localparam int CAPACITY    = 256;
	localparam int GEN_BITS    = 16;
	localparam int OBJECT_BITS = 32;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_MAKE   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// slot table entry: pool position when live, next free slot when free
	typedef struct packed {
		logic [CNT_W-1:0]    link;
		logic [GEN_BITS-1:0] gen;
	} slot_ent_t;

	// dense pool entry
	typedef struct packed {
		logic [OBJECT_BITS-1:0] obj;
		logic [SLOT_W-1:0]      owner;
	} pool_ent_t;
endpackage
`default_nettype wire

// File: rtl/ghp_req_if.sv
// ghp_req_if: request channel of the handle pool, valid/ready plus payload
// depends on ghp_pkg
`default_nettype none
interface ghp_req_if;
	logic                           valid;
	logic                           ready;
	logic [ghp_pkg::OP_W-1:0]        opcode;
	logic [ghp_pkg::SLOT_W-1:0]      handle_slot;
	logic [ghp_pkg::GEN_BITS-1:0]    handle_generation;
	logic [ghp_pkg::SLOT_W-1:0]      position_in;
	logic                           has_object;
	logic [ghp_pkg::OBJECT_BITS-1:0] object_word;

	modport source (output valid, opcode, handle_slot, handle_generation, position_in,
		has_object, object_word, input ready);
	modport sink (input valid, opcode, handle_slot, handle_generation, position_in,
		has_object, object_word, output ready);
endinterface
`default_nettype wire

// File: rtl/ghp_rsp_if.sv
// ghp_rsp_if: result channel of the handle pool, valid/ready plus payload
// depends on ghp_pkg
`default_nettype none
interface ghp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ghp_pkg::STATUS_W-1:0]    status;
	logic [ghp_pkg::SLOT_W-1:0]      out_slot;
	logic [ghp_pkg::GEN_BITS-1:0]    out_generation;
	logic [ghp_pkg::SLOT_W-1:0]      out_position;
	logic [ghp_pkg::OBJECT_BITS-1:0] out_object;

	modport source (output valid, status, out_slot, out_generation, out_position,
		out_object, input ready);
	modport sink (input valid, status, out_slot, out_generation, out_position,
		out_object, output ready);
endinterface
`default_nettype wire

// File: rtl/ghp_ram.sv
// ghp_ram: generic memory, one write port and one read port, registered read
// no dependencies
`default_nettype none
module ghp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/generational_handle_pool.sv
// Generational handle pool: a slot table of generation counts and links and a dense
// object pool, each in a one-read-port memory with a registered read. One operation is
// in work at a time: an insert that grows the table writes both memories on accept, an
// insert from the free list first reads the free slot, lookup and make-handle each make
// two dependent memory reads, and remove also moves the last object into the gap and
// relinks its slot unless it removed the last one; the next operation is accepted the
// cycle after its predecessor's result is loaded into the output register. No clearing
// pass is needed after reset: every read is guarded by the slot and live counts.
// depends on ghp_pkg, ghp_req_if, ghp_rsp_if, ghp_ram, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module generational_handle_pool (
	input wire logic  clk,
	input wire logic  arst_n,
	ghp_req_if.sink   req,
	ghp_rsp_if.source rsp
);
	localparam int SW = ghp_pkg::SLOT_W;
	localparam int CW = ghp_pkg::CNT_W;
	localparam int GW = ghp_pkg::GEN_BITS;
	localparam int OW = ghp_pkg::OBJECT_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INS  = 4'd1;
	localparam logic [3:0] S_CHK1 = 4'd2;
	localparam logic [3:0] S_CHK2 = 4'd3;
	localparam logic [3:0] S_RM1  = 4'd4;
	localparam logic [3:0] S_RM2  = 4'd5;
	localparam logic [3:0] S_MK1  = 4'd6;
	localparam logic [3:0] S_MK2  = 4'd7;
	localparam logic [3:0] S_RESP = 4'd8;

	logic [3:0] state_q;

	logic [ghp_pkg::OP_W-1:0] op_q;
	logic [SW-1:0]            hs_q;
	logic [GW-1:0]            hg_q;
	logic [SW-1:0]            pin_q;
	logic [OW-1:0]            obj_q;
	logic [SW-1:0]            pos_q;
	logic [GW-1:0]            gen_q;
	logic [SW-1:0]            moved_q;

	logic [CW-1:0] slots_in_use_q;
	logic [CW-1:0] free_head_q;
	logic [CW-1:0] live_count_q;

	logic [ghp_pkg::STATUS_W-1:0] res_status_q;
	logic [SW-1:0]                res_slot_q;
	logic [GW-1:0]                res_gen_q;
	logic [SW-1:0]                res_pos_q;
	logic [OW-1:0]                res_obj_q;

	logic                         out_valid_q;
	logic [ghp_pkg::STATUS_W-1:0] out_status_q;
	logic [SW-1:0]                out_slot_q;
	logic [GW-1:0]                out_gen_q;
	logic [SW-1:0]                out_pos_q;
	logic [OW-1:0]                out_obj_q;

	logic               st_we;
	logic [SW-1:0]      st_waddr;
	ghp_pkg::slot_ent_t st_wdata;
	logic [SW-1:0]      st_raddr;
	ghp_pkg::slot_ent_t st_rdata;

	logic               pl_we;
	logic [SW-1:0]      pl_waddr;
	ghp_pkg::pool_ent_t pl_wdata;
	logic [SW-1:0]      pl_raddr;
	ghp_pkg::pool_ent_t pl_rdata;

	ghp_ram #(.WIDTH($bits(ghp_pkg::slot_ent_t)), .DEPTH(ghp_pkg::CAPACITY)) u_slot_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ghp_ram #(.WIDTH($bits(ghp_pkg::pool_ent_t)), .DEPTH(ghp_pkg::CAPACITY)) u_pool_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (pl_raddr),
		.rdata (pl_rdata)
	);

	logic          accept;
	logic          free_avail;
	logic          can_grow;
	logic [CW-1:0] last_cnt;
	logic [OW-1:0] in_obj;
	logic          out_free;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign free_avail = (free_head_q < slots_in_use_q);
	assign can_grow   = (slots_in_use_q < ghp_pkg::CAP_COUNT) &&
		(live_count_q < ghp_pkg::CAP_COUNT);
	assign last_cnt   = live_count_q - CW'(1);
	assign in_obj     = req.has_object ? req.object_word : '0;
	assign out_free   = !out_valid_q || rsp.ready;

	// memory port control
	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = '0;
		st_raddr = '0;
		pl_we    = 1'b0;
		pl_waddr = '0;
		pl_wdata = '0;
		pl_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				st_raddr = (req.opcode == ghp_pkg::OP_INSERT) ? free_head_q[SW-1:0]
					: req.handle_slot;
				pl_raddr = req.position_in;
				// grow: new slot at generation zero
				if (accept && req.opcode == ghp_pkg::OP_INSERT && !free_avail && can_grow) begin
					st_we          = 1'b1;
					st_waddr       = slots_in_use_q[SW-1:0];
					st_wdata.link  = live_count_q;
					st_wdata.gen   = '0;
					pl_we          = 1'b1;
					pl_waddr       = live_count_q[SW-1:0];
					pl_wdata.obj   = in_obj;
					pl_wdata.owner = slots_in_use_q[SW-1:0];
				end
			end
			S_INS: begin
				if (live_count_q < ghp_pkg::CAP_COUNT) begin
					st_we          = 1'b1;
					st_waddr       = free_head_q[SW-1:0];
					st_wdata.link  = live_count_q;
					st_wdata.gen   = st_rdata.gen;
					pl_we          = 1'b1;
					pl_waddr       = live_count_q[SW-1:0];
					pl_wdata.obj   = obj_q;
					pl_wdata.owner = free_head_q[SW-1:0];
				end
			end
			S_CHK1: begin
				pl_raddr = st_rdata.link[SW-1:0];
			end
			S_CHK2: begin
				pl_raddr = last_cnt[SW-1:0];
			end
			S_RM1: begin
				// fill the gap with the last element, push the slot on the free list
				st_we         = 1'b1;
				st_waddr      = hs_q;
				st_wdata.link = free_head_q;
				st_wdata.gen  = GW'(gen_q + 1'b1);
				st_raddr      = pl_rdata.owner;
				if (pos_q != last_cnt[SW-1:0]) begin
					pl_we    = 1'b1;
					pl_waddr = pos_q;
					pl_wdata = pl_rdata;
				end
			end
			S_RM2: begin
				st_we         = 1'b1;
				st_waddr      = moved_q;
				st_wdata.link = {1'b0, pos_q};
				st_wdata.gen  = st_rdata.gen;
			end
			S_MK1: begin
				st_raddr = pl_rdata.owner;
			end
			S_MK2, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slots_in_use_q <= '0;
			free_head_q    <= '0;
			live_count_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority case (1'b1)
							req.opcode == ghp_pkg::OP_INSERT: begin
								if (free_avail) begin
									state_q <= S_INS;
								end else begin
									if (can_grow) begin
										slots_in_use_q <= slots_in_use_q + CW'(1);
										free_head_q    <= slots_in_use_q + CW'(1);
										live_count_q   <= live_count_q + CW'(1);
									end
									state_q <= S_RESP;
								end
							end
							req.opcode == ghp_pkg::OP_MAKE: begin
								state_q <= ({1'b0, req.position_in} < live_count_q) ? S_MK1
									: S_RESP;
							end
							default: begin
								state_q <= ({1'b0, req.handle_slot} < slots_in_use_q) ? S_CHK1
									: S_RESP;
							end
						endcase
					end
				end
				S_INS: begin
					free_head_q <= st_rdata.link;
					if (live_count_q < ghp_pkg::CAP_COUNT) begin
						live_count_q <= live_count_q + CW'(1);
					end
					state_q <= S_RESP;
				end
				S_CHK1: begin
					state_q <= (st_rdata.gen == hg_q && st_rdata.link < live_count_q) ? S_CHK2
						: S_RESP;
				end
				S_CHK2: begin
					state_q <= (pl_rdata.owner == hs_q && op_q == ghp_pkg::OP_REMOVE) ? S_RM1
						: S_RESP;
				end
				S_RM1: begin
					live_count_q <= last_cnt;
					free_head_q  <= {1'b0, hs_q};
					state_q      <= (pos_q != last_cnt[SW-1:0]) ? S_RM2 : S_RESP;
				end
				S_RM2: state_q <= S_RESP;
				S_MK1: state_q <= S_MK2;
				S_MK2: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operation context and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= req.opcode;
				hs_q  <= req.handle_slot;
				hg_q  <= req.handle_generation;
				pin_q <= req.position_in;
				obj_q <= in_obj;
				res_status_q <= ghp_pkg::ST_INVALID;
				res_slot_q   <= '0;
				res_gen_q    <= '0;
				res_pos_q    <= '0;
				res_obj_q    <= '0;
				if (req.opcode == ghp_pkg::OP_INSERT && !free_avail) begin
					if (can_grow) begin
						res_status_q <= ghp_pkg::ST_OK;
						res_slot_q   <= slots_in_use_q[SW-1:0];
						res_pos_q    <= live_count_q[SW-1:0];
						res_obj_q    <= in_obj;
					end else begin
						res_status_q <= ghp_pkg::ST_FULL;
					end
				end
			end
			S_INS: begin
				if (live_count_q < ghp_pkg::CAP_COUNT) begin
					res_status_q <= ghp_pkg::ST_OK;
					res_slot_q   <= free_head_q[SW-1:0];
					res_gen_q    <= st_rdata.gen;
					res_pos_q    <= live_count_q[SW-1:0];
					res_obj_q    <= obj_q;
				end else begin
					res_status_q <= ghp_pkg::ST_FULL;
				end
			end
			S_CHK1: begin
				pos_q <= st_rdata.link[SW-1:0];
				gen_q <= st_rdata.gen;
			end
			S_CHK2: begin
				if (pl_rdata.owner == hs_q && op_q == ghp_pkg::OP_LOOKUP) begin
					res_status_q <= ghp_pkg::ST_OK;
					res_slot_q   <= hs_q;
					res_gen_q    <= hg_q;
					res_pos_q    <= pos_q;
					res_obj_q    <= pl_rdata.obj;
				end
			end
			S_RM1: begin
				moved_q      <= pl_rdata.owner;
				res_status_q <= ghp_pkg::ST_OK;
			end
			S_MK1: begin
				res_slot_q <= pl_rdata.owner;
			end
			S_MK2: begin
				res_status_q <= ghp_pkg::ST_OK;
				res_gen_q    <= st_rdata.gen;
				res_pos_q    <= pin_q;
			end
			S_RM2, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_gen_q    <= res_gen_q;
			out_pos_q    <= res_pos_q;
			out_obj_q    <= res_obj_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.out_slot       = out_slot_q;
	assign rsp.out_generation = out_gen_q;
	assign rsp.out_position   = out_pos_q;
	assign rsp.out_object     = out_obj_q;

	`ASSERT_HOLDS(a_live_le_slots, live_count_q <= slots_in_use_q)
	`ASSERT_HOLDS(a_head_le_slots, free_head_q <= slots_in_use_q)
	`ASSERT_HOLDS(a_slots_le_cap, slots_in_use_q <= ghp_pkg::CAP_COUNT)
	`ASSERT_IMPLIES(a_full_zero, rsp.valid && rsp.status == ghp_pkg::ST_FULL,
		rsp.out_slot == '0 && rsp.out_generation == '0 && rsp.out_object == '0)
	`ASSERT_IMPLIES(a_live_moves_in_commit, live_count_q != $past(live_count_q),
		$past(state_q) == S_IDLE || $past(state_q) == S_INS || $past(state_q) == S_RM1)
endmodule
`default_nettype wire

// File: dv/ghp_pool_checker.sv
// ghp_pool_checker: watches the request and result channels of the handle pool,
// keeps its own copy of the slot table and dense pool, and compares every result
// depends on ghp_pkg, ghp_req_if, ghp_rsp_if
`timescale 1ns / 1ps
module ghp_pool_checker (
	input  logic clk,
	input  logic arst_n,
	ghp_req_if   req,
	ghp_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [ghp_pkg::STATUS_W-1:0]    status;
		logic [ghp_pkg::SLOT_W-1:0]      slot;
		logic [ghp_pkg::GEN_BITS-1:0]    gen;
		logic [ghp_pkg::SLOT_W-1:0]      pos;
		logic [ghp_pkg::OBJECT_BITS-1:0] obj;
	} pool_result_t;

	// slot table: pool position when live, next free slot when free
	logic [ghp_pkg::CNT_W-1:0]       tbl_link [ghp_pkg::CAPACITY];
	logic [ghp_pkg::GEN_BITS-1:0]    tbl_gen [ghp_pkg::CAPACITY];
	logic [ghp_pkg::OBJECT_BITS-1:0] pool_obj [ghp_pkg::CAPACITY];
	logic [ghp_pkg::SLOT_W-1:0]      pool_owner [ghp_pkg::CAPACITY];
	logic [ghp_pkg::CNT_W-1:0]       n_slots;
	logic [ghp_pkg::CNT_W-1:0]       free_top;
	logic [ghp_pkg::CNT_W-1:0]       n_live;

	pool_result_t expected_results[$];
	int mismatches = 0;
	int waiting = 0;

	assign fail_count = mismatches;
	assign pending = waiting;

	function automatic bit handle_live(logic [ghp_pkg::SLOT_W-1:0] s,
			logic [ghp_pkg::GEN_BITS-1:0] g);
		logic [ghp_pkg::CNT_W-1:0] p;
		if (ghp_pkg::CNT_W'(s) >= n_slots || tbl_gen[s] != g)
			return 1'b0;
		p = tbl_link[s];
		// a free slot links into the free list, so it has no owner entry
		return p < n_live && pool_owner[p[ghp_pkg::SLOT_W-1:0]] == s;
	endfunction

	function automatic pool_result_t apply_op(logic [ghp_pkg::OP_W-1:0] op,
			logic [ghp_pkg::SLOT_W-1:0] hs, logic [ghp_pkg::GEN_BITS-1:0] hg,
			logic [ghp_pkg::SLOT_W-1:0] pin, logic has,
			logic [ghp_pkg::OBJECT_BITS-1:0] word);
		pool_result_t r;
		logic [ghp_pkg::SLOT_W-1:0] s;
		logic [ghp_pkg::SLOT_W-1:0] at;
		logic [ghp_pkg::SLOT_W-1:0] last;
		logic [ghp_pkg::SLOT_W-1:0] moved;
		r = '0;
		case (op)
			ghp_pkg::OP_INSERT: begin
				if (free_top < n_slots) begin
					s = free_top[ghp_pkg::SLOT_W-1:0];
					free_top = tbl_link[s];
				end else if (n_slots < ghp_pkg::CAP_COUNT) begin
					s = n_slots[ghp_pkg::SLOT_W-1:0];
					tbl_gen[s] = '0;
					n_slots = n_slots + 1'b1;
					free_top = n_slots;
				end else begin
					r.status = ghp_pkg::ST_FULL;
					return r;
				end
				at = n_live[ghp_pkg::SLOT_W-1:0];
				tbl_link[s] = n_live;
				pool_obj[at] = has ? word : '0;
				pool_owner[at] = s;
				r.slot = s;
				r.gen = tbl_gen[s];
				r.pos = at;
				r.obj = pool_obj[at];
				n_live = n_live + 1'b1;
			end
			ghp_pkg::OP_REMOVE: begin
				if (!handle_live(hs, hg)) begin
					r.status = ghp_pkg::ST_INVALID;
				end else begin
					at = tbl_link[hs][ghp_pkg::SLOT_W-1:0];
					last = ghp_pkg::SLOT_W'(n_live - 1'b1);
					moved = pool_owner[last];
					// last object fills the gap
					if (at != last) begin
						tbl_link[moved] = ghp_pkg::CNT_W'(at);
						pool_obj[at] = pool_obj[last];
						pool_owner[at] = moved;
					end
					n_live = n_live - 1'b1;
					tbl_gen[hs] = tbl_gen[hs] + 1'b1;
					tbl_link[hs] = free_top;
					free_top = ghp_pkg::CNT_W'(hs);
				end
			end
			ghp_pkg::OP_LOOKUP: begin
				if (!handle_live(hs, hg)) begin
					r.status = ghp_pkg::ST_INVALID;
				end else begin
					r.slot = hs;
					r.gen = hg;
					r.pos = tbl_link[hs][ghp_pkg::SLOT_W-1:0];
					r.obj = pool_obj[r.pos];
				end
			end
			ghp_pkg::OP_MAKE: begin
				if (ghp_pkg::CNT_W'(pin) >= n_live) begin
					r.status = ghp_pkg::ST_INVALID;
				end else begin
					s = pool_owner[pin];
					r.slot = s;
					r.gen = tbl_gen[s];
					r.pos = pin;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void match_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			n_slots = '0;
			free_top = '0;
			n_live = '0;
			expected_results.delete();
			waiting = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: status %0d slot %0d",
						rsp.status, rsp.out_slot);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					match_field("status", want.status, rsp.status);
					match_field("out_slot", want.slot, rsp.out_slot);
					match_field("out_generation", want.gen, rsp.out_generation);
					match_field("out_position", want.pos, rsp.out_position);
					match_field("out_object", want.obj, rsp.out_object);
				end
			end
			if (req.valid && req.ready)
				expected_results = {expected_results, apply_op(req.opcode,
					req.handle_slot, req.handle_generation, req.position_in,
					req.has_object, req.object_word)};
			waiting = expected_results.size();
		end
	end

endmodule

// File: dv/tb_generational_handle_pool.sv
// tb_generational_handle_pool: drives requests into the handle pool with random gaps
// and result stalls, and gives the verdict from ghp_pool_checker
// depends on ghp_pkg, ghp_req_if, ghp_rsp_if, ghp_pool_checker, generational_handle_pool
`timescale 1ns / 1ps
module tb_generational_handle_pool;

	typedef struct packed {
		logic [ghp_pkg::SLOT_W-1:0]   slot;
		logic [ghp_pkg::GEN_BITS-1:0] gen;
	} handle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	ghp_req_if req_ch();
	ghp_rsp_if rsp_ch();

	int fail_count;
	int pending;

	generational_handle_pool DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	ghp_pool_checker pool_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// result side: ready in random runs and stall bursts
	int stall_pct = 0;
	int gap_pct = 0;
	int stall_left = 0;
	int run_left = 0;

	assign rsp_ch.ready = sink_ready;

	always @(negedge clk) begin
		if (stall_pct == 0) begin
			sink_ready <= 1'b1;
		end else if (stall_left != 0) begin
			sink_ready <= 1'b0;
			stall_left--;
		end else if (run_left != 0) begin
			sink_ready <= 1'b1;
			run_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			sink_ready <= 1'b0;
			stall_left = $urandom_range(1, 16) - 1;
		end else begin
			sink_ready <= 1'b1;
			run_left = $urandom_range(1, 16) - 1;
		end
	end

	// handles handed out by the pool, fed back into the stimulus
	logic [ghp_pkg::OP_W-1:0] ops_in_flight[$];
	handle_t live_h[$];
	handle_t stale_h[$];
	handle_t last_handle;
	int full_hits = 0;
	int sent_total = 0;

	always @(posedge clk) begin
		logic [ghp_pkg::OP_W-1:0] op;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready && ops_in_flight.size() != 0) begin
				op = ops_in_flight.pop_front();
				if (op == ghp_pkg::OP_INSERT && rsp_ch.status == ghp_pkg::ST_OK) begin
					last_handle = '{rsp_ch.out_slot, rsp_ch.out_generation};
					live_h = {live_h, last_handle};
				end else if (op == ghp_pkg::OP_INSERT && rsp_ch.status == ghp_pkg::ST_FULL) begin
					full_hits++;
				end
			end
			if (req_ch.valid && req_ch.ready)
				ops_in_flight = {ops_in_flight, req_ch.opcode};
		end
	end

	task automatic issue(logic [ghp_pkg::OP_W-1:0] op, logic [ghp_pkg::SLOT_W-1:0] hs,
			logic [ghp_pkg::GEN_BITS-1:0] hg, logic [ghp_pkg::SLOT_W-1:0] pin, logic has,
			logic [ghp_pkg::OBJECT_BITS-1:0] word);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.handle_slot <= hs;
		req_ch.handle_generation <= hg;
		req_ch.position_in <= pin;
		req_ch.has_object <= has;
		req_ch.object_word <= word;
		do @(posedge clk); while (!req_ch.ready);
		sent_total++;
	endtask

	task automatic pause_requests(int cycles);
		@(negedge clk) req_ch.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk) req_ch.valid <= 1'b0;
		while (ops_in_flight.size() != 0) @(negedge clk);
	endtask

	task automatic random_request(int ins_pct, int rem_pct);
		int roll;
		int pick;
		int idx;
		logic [ghp_pkg::OP_W-1:0] op;
		handle_t h;
		logic [ghp_pkg::SLOT_W-1:0] pin;
		logic [ghp_pkg::OBJECT_BITS-1:0] word;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = ghp_pkg::OP_INSERT;
		else if (roll < ins_pct + rem_pct)
			op = ghp_pkg::OP_REMOVE;
		else
			op = $urandom_range(0, 1) ? ghp_pkg::OP_LOOKUP : ghp_pkg::OP_MAKE;
		h.slot = ghp_pkg::SLOT_W'($urandom);
		h.gen = ghp_pkg::GEN_BITS'($urandom);
		pin = ghp_pkg::SLOT_W'($urandom);
		pick = $urandom_range(0, 99);
		if (op == ghp_pkg::OP_REMOVE || op == ghp_pkg::OP_LOOKUP) begin
			if (pick < 75 && live_h.size() != 0) begin
				idx = $urandom_range(0, live_h.size() - 1);
				h = live_h[idx];
				if (op == ghp_pkg::OP_REMOVE) begin
					live_h.delete(idx);
					stale_h = {stale_h, h};
					if (stale_h.size() > 64)
						void'(stale_h.pop_front());
				end
			end else if (pick < 88 && stale_h.size() != 0) begin
				h = stale_h[$urandom_range(0, stale_h.size() - 1)];
			end else if (pick < 94 && live_h.size() != 0) begin
				// right slot, one generation bit off
				h = live_h[$urandom_range(0, live_h.size() - 1)];
				h.gen = h.gen ^ (ghp_pkg::GEN_BITS'(1) << $urandom_range(0,
					ghp_pkg::GEN_BITS - 1));
			end
		end else if (op == ghp_pkg::OP_MAKE && pick < 85) begin
			pin = ghp_pkg::SLOT_W'($urandom_range(0, live_h.size() + 2));
		end
		case ($urandom_range(0, 9))
			0: word = '1;
			1: word = '0;
			default: word = ghp_pkg::OBJECT_BITS'($urandom);
		endcase
		issue(op, h.slot, h.gen, pin, 1'($urandom_range(0, 1)), word);
	endtask

	task automatic random_items(int count, int ins_pct, int rem_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < gap_pct)
				pause_requests($urandom_range(1, 16));
			random_request(ins_pct, rem_pct);
		end
	endtask

	initial begin
		int fill_items;
		int settle;
		logic [ghp_pkg::GEN_BITS-1:0] reuse_gen;
		handle_t reuse_h;
		req_ch.valid = 1'b0;
		req_ch.opcode = ghp_pkg::OP_INSERT;
		req_ch.handle_slot = '0;
		req_ch.handle_generation = '0;
		req_ch.position_in = '0;
		req_ch.has_object = 1'b0;
		req_ch.object_word = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// empty table: every handle and position is invalid
		issue(ghp_pkg::OP_LOOKUP, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_MAKE, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_INSERT, '1, '1, '1, 1, '1);
		issue(ghp_pkg::OP_INSERT, 0, 0, 0, 0, 32'hA5A5_A5A5);
		issue(ghp_pkg::OP_INSERT, 0, 0, 0, 1, 32'h0000_0001);
		issue(ghp_pkg::OP_LOOKUP, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_LOOKUP, 1, 0, 0, 0, 0);
		issue(ghp_pkg::OP_LOOKUP, 2, '1, 0, 0, 0);
		issue(ghp_pkg::OP_LOOKUP, '1, 0, 0, 0, 0);
		issue(ghp_pkg::OP_MAKE, 0, 0, 2, 0, 0);
		issue(ghp_pkg::OP_MAKE, 0, 0, 3, 0, 0);
		issue(ghp_pkg::OP_MAKE, 0, 0, '1, 0, 0);
		// remove the first object, then the same handle again
		issue(ghp_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
		// freed slot with its new generation is still not live
		issue(ghp_pkg::OP_LOOKUP, 0, 1, 0, 0, 0);
		issue(ghp_pkg::OP_LOOKUP, 2, 0, 0, 0, 0);
		issue(ghp_pkg::OP_MAKE, 0, 0, 0, 0, 0);
		issue(ghp_pkg::OP_INSERT, 0, 0, 0, 1, 32'h8000_0000);
		issue(ghp_pkg::OP_REMOVE, 0, 1, 0, 0, 0);
		issue(ghp_pkg::OP_REMOVE, 1, 0, 0, 0, 0);
		issue(ghp_pkg::OP_REMOVE, 2, 0, 0, 0, 0);
		issue(ghp_pkg::OP_INSERT, 0, 0, 0, 1, 32'h7FFF_FFFF);

		// one slot through insert and remove, its generation steps each round
		drain_results();
		issue(ghp_pkg::OP_INSERT, 0, 0, 0, 1, 32'h1234_5678);
		drain_results();
		reuse_h = last_handle;
		issue(ghp_pkg::OP_REMOVE, reuse_h.slot, reuse_h.gen, 0, 0, 0);
		reuse_gen = reuse_h.gen + 1'b1;
		repeat (12) begin
			issue(ghp_pkg::OP_INSERT, ghp_pkg::SLOT_W'($urandom),
				ghp_pkg::GEN_BITS'($urandom), ghp_pkg::SLOT_W'($urandom),
				1'($urandom_range(0, 1)), ghp_pkg::OBJECT_BITS'($urandom));
			issue(ghp_pkg::OP_REMOVE, reuse_h.slot, reuse_gen,
				ghp_pkg::SLOT_W'($urandom), 0, 0);
			reuse_gen = reuse_gen + 1'b1;
		end
		issue(ghp_pkg::OP_LOOKUP, reuse_h.slot, reuse_h.gen, 0, 0, 0);

		gap_pct = 25;
		stall_pct = 25;
		random_items(80, 45, 25);
		gap_pct = 0;
		stall_pct = 0;
		random_items(40, 45, 25);
		gap_pct = 25;
		stall_pct = 25;
		random_items(80, 45, 25);

		// grow the table until inserts are refused
		gap_pct = 20;
		stall_pct = 20;
		fill_items = 0;
		while (full_hits < 3 && fill_items < 300) begin
			random_items(1, 90, 0);
			fill_items++;
		end

		random_items(120, 25, 50);

		// last part: no gaps, no stalls
		gap_pct = 0;
		stall_pct = 0;
		random_items(80, 30, 40);

		@(negedge clk) req_ch.valid <= 1'b0;
		settle = 0;
		while (pending != 0 && settle < 5000) begin
			@(negedge clk);
			settle++;
		end
		repeat (8) @(negedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);
		$display("%0d requests sent; inserts refused on a full table %0d times", sent_total,
			full_hits);
		$display("slot %0d reused 13 times, a new generation on each round", reuse_h.slot);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
